### sv/ttfd_pkg.sv
`timescale 1ns / 1ps
// Package for the tiled texel format decoder: sizes, format codes,
// register indexes and the structs passed between modules. No dependencies.
package ttfd_pkg;

  // Image geometry
  localparam int MAX_TILES = 128;
  localparam int TILE_SIDE = 8;
  localparam int TILE_BITS = $clog2(TILE_SIDE);
  localparam int IDX_W     = 2 * TILE_BITS;
  localparam int TCNT_W    = (MAX_TILES > 1) ? $clog2(MAX_TILES) : 1;

  // Field widths
  localparam int RAW_W   = 32;
  localparam int COORD_W = 10;
  localparam int CHAN_W  = 8;
  localparam int FMT_W   = 4;
  localparam int TILES_W = 8;

  // Configuration port
  localparam int DATA_W    = 32;
  localparam int ADDR_W    = 4;
  localparam int REG_IDX_W = 2;

  localparam logic [REG_IDX_W-1:0] REG_TEXEL_FORMAT    = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_WIDTH_IN_TILES  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_HEIGHT_IN_TILES = 2'd2;

  // Texel format codes
  localparam logic [FMT_W-1:0] FMT_RGBA8888 = 4'd0;
  localparam logic [FMT_W-1:0] FMT_RGB888   = 4'd1;
  localparam logic [FMT_W-1:0] FMT_RGBA5551 = 4'd2;
  localparam logic [FMT_W-1:0] FMT_RGB565   = 4'd3;
  localparam logic [FMT_W-1:0] FMT_RGBA4444 = 4'd4;
  localparam logic [FMT_W-1:0] FMT_LA88     = 4'd5;
  localparam logic [FMT_W-1:0] FMT_HL8      = 4'd6;
  localparam logic [FMT_W-1:0] FMT_L8       = 4'd7;
  localparam logic [FMT_W-1:0] FMT_A8       = 4'd8;
  localparam logic [FMT_W-1:0] FMT_LA44     = 4'd9;
  localparam logic [FMT_W-1:0] FMT_L4       = 4'd10;
  localparam logic [FMT_W-1:0] FMT_A4       = 4'd11;

  typedef struct packed {
    logic [FMT_W-1:0]   texel_format;
    logic [TILES_W-1:0] width_in_tiles;
    logic [TILES_W-1:0] height_in_tiles;
  } cfg_t;

  typedef struct packed {
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
    logic               last_texel;
  } pos_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] alpha;
  } rgba_t;

endpackage

### sv/ttfd_stream_if.sv
`timescale 1ns / 1ps
// Valid/ready stream interfaces for texel input and pixel output.
// Depends on ttfd_pkg.
interface ttfd_texel_if import ttfd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [RAW_W-1:0] raw_texel;

  modport source (output valid, output raw_texel, input ready);
  modport sink   (input valid, input raw_texel, output ready);
endinterface

interface ttfd_pixel_if import ttfd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] pixel_x;
  logic [COORD_W-1:0] pixel_y;
  logic [CHAN_W-1:0]  red;
  logic [CHAN_W-1:0]  green;
  logic [CHAN_W-1:0]  blue;
  logic [CHAN_W-1:0]  alpha;
  logic               last_texel;

  modport source (output valid, output pixel_x, output pixel_y, output red, output green,
                  output blue, output alpha, output last_texel, input ready);
  modport sink   (input valid, input pixel_x, input pixel_y, input red, input green,
                  input blue, input alpha, input last_texel, output ready);
endinterface

### sv/ttfd_apb_regs.sv
`timescale 1ns / 1ps
// APB-style configuration registers: format, width and height in tiles.
// Depends on ttfd_pkg.
module ttfd_apb_regs
  import ttfd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  cfg_t                 cfg_r, cfg_nxt;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;

  // Register write decode; writes beyond the register list are dropped.
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_idx)
        REG_TEXEL_FORMAT:    cfg_nxt.texel_format    = pwdata[FMT_W-1:0];
        REG_WIDTH_IN_TILES:  cfg_nxt.width_in_tiles  = pwdata[TILES_W-1:0];
        REG_HEIGHT_IN_TILES: cfg_nxt.height_in_tiles = pwdata[TILES_W-1:0];
        default:             cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.texel_format    <= FMT_RGBA8888;
      cfg_r.width_in_tiles  <= TILES_W'(1);
      cfg_r.height_in_tiles <= TILES_W'(1);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Read-back mux.
  always_comb begin
    case (reg_idx)
      REG_TEXEL_FORMAT:    prdata = DATA_W'(cfg_r.texel_format);
      REG_WIDTH_IN_TILES:  prdata = DATA_W'(cfg_r.width_in_tiles);
      REG_HEIGHT_IN_TILES: prdata = DATA_W'(cfg_r.height_in_tiles);
      default:             prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

### sv/ttfd_tile_walker.sv
`timescale 1ns / 1ps
// Texel position counters: Morton index within a tile, tile column and row.
// Depends on ttfd_pkg.
module ttfd_tile_walker
  import ttfd_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic advance,
  input  cfg_t cfg,
  output pos_t pos
);

  localparam int CMP_W = 16;
  localparam int POS_W = TCNT_W + TILE_BITS;

  logic [IDX_W-1:0]     idx_r, idx_nxt;
  logic [TCNT_W-1:0]    col_r, col_nxt;
  logic [TCNT_W-1:0]    row_r, row_nxt;
  logic [TILE_BITS-1:0] lx, ly;
  logic [POS_W-1:0]     x_full, y_full;
  logic [TILES_W-1:0]   w_lim, h_lim;
  logic [CMP_W-1:0]     col_inc, row_inc;
  logic                 end_tile, end_row, last;

  // Clamp a tile count to the range 1 .. MAX_TILES.
  function automatic logic [TILES_W-1:0] tiles_limit(input logic [TILES_W-1:0] v);
    logic [TILES_W-1:0] res;
    res = v;
    if (v == '0) res = TILES_W'(1);
    else if (int'(v) > MAX_TILES) res = TILES_W'(MAX_TILES);
    return res;
  endfunction

  // Z order: even index bits give x, odd bits give y.
  always_comb begin
    for (int k = 0; k < TILE_BITS; k++) begin
      lx[k] = idx_r[2*k];
      ly[k] = idx_r[2*k+1];
    end
  end

  assign w_lim    = tiles_limit(cfg.width_in_tiles);
  assign h_lim    = tiles_limit(cfg.height_in_tiles);
  assign col_inc  = CMP_W'(col_r) + CMP_W'(1);
  assign row_inc  = CMP_W'(row_r) + CMP_W'(1);
  assign end_tile = (idx_r == {IDX_W{1'b1}});
  assign end_row  = end_tile && (col_inc >= CMP_W'(w_lim));
  assign last     = end_row && (row_inc >= CMP_W'(h_lim));

  assign x_full         = {col_r, lx};
  assign y_full         = {row_r, ly};
  assign pos.pixel_x    = COORD_W'(x_full);
  assign pos.pixel_y    = COORD_W'(y_full);
  assign pos.last_texel = last;

  // Counter advance on every accepted texel.
  always_comb begin
    idx_nxt = idx_r;
    col_nxt = col_r;
    row_nxt = row_r;
    if (advance) begin
      idx_nxt = idx_r + IDX_W'(1);
      if (end_tile) begin
        if (end_row) begin
          col_nxt = '0;
          row_nxt = last ? '0 : TCNT_W'(row_inc);
        end else begin
          col_nxt = TCNT_W'(col_inc);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      col_r <= '0;
      row_r <= '0;
    end else begin
      idx_r <= idx_nxt;
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

### sv/ttfd_color_decode.sv
`timescale 1ns / 1ps
// Texel format unpacking into 8-bit red, green, blue and alpha.
// Depends on ttfd_pkg.
module ttfd_color_decode
  import ttfd_pkg::*;
(
  input  logic [FMT_W-1:0] texel_format,
  input  logic [RAW_W-1:0] raw_texel,
  output rgba_t            rgba
);

  // Widen narrow channels by bit replication.
  function automatic logic [7:0] widen4(input logic [3:0] v);
    return {v, v};
  endfunction

  function automatic logic [7:0] widen5(input logic [4:0] v);
    return {v, v[4:2]};
  endfunction

  function automatic logic [7:0] widen6(input logic [5:0] v);
    return {v, v[5:4]};
  endfunction

  logic [7:0]  b0, b1, b2, b3;
  logic [15:0] v16;

  assign b0  = raw_texel[7:0];
  assign b1  = raw_texel[15:8];
  assign b2  = raw_texel[23:16];
  assign b3  = raw_texel[31:24];
  assign v16 = raw_texel[15:0];

  // Per-format channel selection; unused codes give all zero.
  always_comb begin
    rgba = '0;
    case (texel_format)
      FMT_RGBA8888: rgba = '{red: b3, green: b2, blue: b1, alpha: b0};
      FMT_RGB888:   rgba = '{red: b2, green: b1, blue: b0, alpha: 8'hFF};
      FMT_RGBA5551: begin
        rgba.red   = widen5(v16[15:11]);
        rgba.green = widen5(v16[10:6]);
        rgba.blue  = widen5(v16[5:1]);
        rgba.alpha = v16[0] ? 8'hFF : 8'h00;
      end
      FMT_RGB565: begin
        rgba.red   = widen5(v16[15:11]);
        rgba.green = widen6(v16[10:5]);
        rgba.blue  = widen5(v16[4:0]);
        rgba.alpha = 8'hFF;
      end
      FMT_RGBA4444: begin
        rgba.red   = widen4(v16[15:12]);
        rgba.green = widen4(v16[11:8]);
        rgba.blue  = widen4(v16[7:4]);
        rgba.alpha = widen4(v16[3:0]);
      end
      FMT_LA88: rgba = '{red: b1, green: b1, blue: b1, alpha: b0};
      FMT_HL8:  rgba = '{red: b1, green: b0, blue: 8'h00, alpha: 8'hFF};
      FMT_L8:   rgba = '{red: b0, green: b0, blue: b0, alpha: 8'hFF};
      FMT_A8:   rgba = '{red: 8'hFF, green: 8'hFF, blue: 8'hFF, alpha: b0};
      FMT_LA44: begin
        rgba.red   = widen4(b0[7:4]);
        rgba.green = widen4(b0[7:4]);
        rgba.blue  = widen4(b0[7:4]);
        rgba.alpha = widen4(b0[3:0]);
      end
      FMT_L4: begin
        rgba.red   = widen4(raw_texel[3:0]);
        rgba.green = widen4(raw_texel[3:0]);
        rgba.blue  = widen4(raw_texel[3:0]);
        rgba.alpha = 8'hFF;
      end
      FMT_A4: begin
        rgba.red   = 8'hFF;
        rgba.green = 8'hFF;
        rgba.blue  = 8'hFF;
        rgba.alpha = widen4(raw_texel[3:0]);
      end
      default: rgba = '0;
    endcase
  end

endmodule

### sv/tiled_texel_format_decoder_top.sv
`timescale 1ns / 1ps
// Top level of the tiled texel format decoder.
// Depends on ttfd_pkg, the stream interfaces and the three submodules.
//
//   Channel     Kind          Carries
//   in_texel    valid/ready   raw_texel, one texel per transfer
//   out_pixel   valid/ready   pixel_x, pixel_y, red, green, blue, alpha, last_texel
//   cfg (APB)   write/read    texel_format, width_in_tiles, height_in_tiles
//
// One texel per cycle while the output is not stalled; a texel's pixel passes
// the input register, then the result register, of the two-stage pipeline.
// Synchronous active-low reset clears both stage valids, the position
// counters and the registers to their defaults. A stalled output holds its
// result while the input register still takes a texel if it is empty.
module tiled_texel_format_decoder_top
  import ttfd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  ttfd_texel_if.sink        in_texel,
  ttfd_pixel_if.source      out_pixel,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  cfg_t             cfg;
  pos_t             walk_pos;
  rgba_t            s1_rgba;

  logic             s1_valid_r, s1_valid_nxt;
  logic [RAW_W-1:0] s1_raw_r;
  pos_t             s1_pos_r;
  logic             out_valid_r, out_valid_nxt;
  pos_t             out_pos_r;
  rgba_t            out_rgba_r;

  logic             in_xfer;
  logic             s1_go;

  ttfd_apb_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ttfd_tile_walker u_walker (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (in_xfer),
    .cfg     (cfg),
    .pos     (walk_pos)
  );

  ttfd_color_decode u_decode (
    .texel_format (cfg.texel_format),
    .raw_texel    (s1_raw_r),
    .rgba         (s1_rgba)
  );

  // Pipeline handshake: a stage moves on when the one after it is free.
  assign s1_go          = !out_valid_r || out_pixel.ready;
  assign in_texel.ready = !s1_valid_r || s1_go;
  assign in_xfer        = in_texel.valid && in_texel.ready;

  assign s1_valid_nxt  = in_xfer ? 1'b1 : (s1_go ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = s1_go ? s1_valid_r : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Input register captures the texel with its position.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_raw_r <= in_texel.raw_texel;
      s1_pos_r <= walk_pos;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (s1_go && s1_valid_r) begin
      out_pos_r  <= s1_pos_r;
      out_rgba_r <= s1_rgba;
    end
  end

  assign out_pixel.valid      = out_valid_r;
  assign out_pixel.pixel_x    = out_pos_r.pixel_x;
  assign out_pixel.pixel_y    = out_pos_r.pixel_y;
  assign out_pixel.last_texel = out_pos_r.last_texel;
  assign out_pixel.red        = out_rgba_r.red;
  assign out_pixel.green      = out_rgba_r.green;
  assign out_pixel.blue       = out_rgba_r.blue;
  assign out_pixel.alpha      = out_rgba_r.alpha;

endmodule
